@@ design/nsbc_pkg.sv @@
// ----------------------------------------------------------------------------
// nsbc_pkg
// Shared types, constants and the byte-wide crc step for the superblock
// checker.
// ----------------------------------------------------------------------------
package nsbc_pkg;

  localparam int MAX_CHECKED_BYTES = 1024;
  localparam int MAX_SHIFT         = 6;
  localparam int POS_W             = $clog2(MAX_CHECKED_BYTES) + 1;
  localparam int HELD_N            = 12;
  localparam int HELD_W            = $clog2(HELD_N);
  localparam int QUEUE_DEPTH       = 4;
  localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);
  localparam int REPLAY_N          = 16;
  localparam int REPLAY_W          = $clog2(REPLAY_N);

  localparam logic [15:0] SB_MAGIC = 16'h3434;
  localparam logic [15:0] MIN_LEN  = 16'h0030;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  localparam int OFF_MAGIC = 'h06;
  localparam int OFF_LEN   = 'h08;
  localparam int OFF_SEED  = 'h0C;
  localparam int OFF_CRC   = 'h10;
  localparam int OFF_SHIFT = 'h14;
  localparam int OFF_SIZE  = 'h20;

  typedef enum logic [2:0] {
    V_OK           = 3'd0,
    V_BAD_MAGIC    = 3'd1,
    V_BAD_LENGTH   = 3'd2,
    V_BAD_SHIFT    = 3'd3,
    V_CRC_MISMATCH = 3'd4,
    V_TRUNCATED    = 3'd5
  } verdict_t;

  typedef enum logic {
    ST_RUN,
    ST_REPLAY
  } back_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_image;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

@@ design/nsbc_if.sv @@
// ----------------------------------------------------------------------------
// nsbc_if
// Valid/ready channels for superblock bytes and for verdicts.
// ----------------------------------------------------------------------------
interface nsbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       end_of_image;

  modport source (output valid, output data_byte, output first_byte,
                  output end_of_image, input ready);
  modport sink   (input valid, input data_byte, input first_byte,
                  input end_of_image, output ready);
endinterface

interface nsbc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [2:0]  block_shift;
  logic [63:0] device_size;
  logic        size_usable;

  modport source (output valid, output verdict, output block_shift,
                  output device_size, output size_usable, input ready);
  modport sink   (input valid, input verdict, input block_shift,
                  input device_size, input size_usable, output ready);
endinterface

@@ design/nsbc_front.sv @@
// ----------------------------------------------------------------------------
// nsbc_front
// Accepts input words and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module nsbc_front (
  input  logic                clk,
  input  logic                rst,
  nsbc_in_if.sink             byte_in,
  output nsbc_pkg::q_head_t   head,
  input  logic                pop
);

  nsbc_pkg::entry_t                   slots [nsbc_pkg::QUEUE_DEPTH];
  logic [nsbc_pkg::QPTR_W-1:0]        wr_ptr;
  logic [nsbc_pkg::QPTR_W-1:0]        rd_ptr;
  logic [nsbc_pkg::QCNT_W-1:0]        count;
  logic                               push;
  logic                               do_pop;

  function automatic logic [nsbc_pkg::QPTR_W-1:0] ptr_inc(
      input logic [nsbc_pkg::QPTR_W-1:0] p);
    return (p == nsbc_pkg::QPTR_W'(nsbc_pkg::QUEUE_DEPTH - 1)) ?
           '0 : p + 1'b1;
  endfunction

  assign byte_in.ready = (count != nsbc_pkg::QCNT_W'(nsbc_pkg::QUEUE_DEPTH));
  assign push          = byte_in.valid && byte_in.ready;
  assign do_pop        = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{data_byte:    byte_in.data_byte,
                         first_byte:   byte_in.first_byte,
                         end_of_image: byte_in.end_of_image};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= nsbc_pkg::QCNT_W'(nsbc_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a push");
`endif

endmodule

@@ design/nsbc_back.sv @@
// ----------------------------------------------------------------------------
// nsbc_back
// Walks the superblock bytes: field capture, header checks, crc and verdict.
// ----------------------------------------------------------------------------
module nsbc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  nsbc_pkg::q_head_t    head,
  output logic                 pop,
  input  logic [63:0]          image_offset,
  nsbc_out_if.source           result
);

  localparam int PW = nsbc_pkg::POS_W;

  nsbc_pkg::back_state_t              state, state_next;
  logic [nsbc_pkg::REPLAY_W-1:0]      rcnt, rcnt_next;

  logic [PW-1:0]   pos, pos_next;
  logic [PW-1:0]   len, len_next;
  logic [7:0]      len_lo, len_lo_next;
  logic [7:0]      magic_lo, magic_lo_next;
  logic [31:0]     seed, seed_next;
  logic [31:0]     stored, stored_next;
  logic [31:0]     crc, crc_next;
  logic [31:0]     shift, shift_next;
  logic [63:0]     size, size_next;
  logic            idle, idle_next;
  logic [7:0]      held [nsbc_pkg::HELD_N];

  logic            active;
  logic            emit;
  logic            start_replay;
  nsbc_pkg::verdict_t vcode;
  logic [PW-1:0]   p;
  logic [7:0]      b;
  logic [15:0]     len16;
  logic [7:0]      replay_byte;
  logic [64:0]     wrap_sum;

  // -------- next state
  always_comb begin
    state_next = state;
    rcnt_next  = rcnt;
    unique case (state)
      nsbc_pkg::ST_RUN: begin
        rcnt_next = '0;
        if (start_replay) begin
          state_next = nsbc_pkg::ST_REPLAY;
        end
      end
      nsbc_pkg::ST_REPLAY: begin
        rcnt_next = rcnt + 1'b1;
        if (rcnt == nsbc_pkg::REPLAY_W'(nsbc_pkg::REPLAY_N - 1)) begin
          state_next = nsbc_pkg::ST_RUN;
        end
      end
      default: state_next = nsbc_pkg::ST_RUN;
    endcase
  end

  assign pop = (state == nsbc_pkg::ST_RUN) && head.valid &&
               (!result.valid || result.ready);

  assign b      = head.entry.data_byte;
  assign p      = head.entry.first_byte ? '0 : pos;
  assign active = pop && (head.entry.first_byte || !idle);
  assign len16  = {b, len_lo};

  // bytes 0..11 from the hold registers, then the seed bytes 12..15
  always_comb begin
    if (rcnt < nsbc_pkg::REPLAY_W'(nsbc_pkg::HELD_N)) begin
      replay_byte = held[rcnt[nsbc_pkg::HELD_W-1:0]];
    end else begin
      replay_byte = seed[8*rcnt[1:0] +: 8];
    end
  end

  // -------- datapath and verdict
  always_comb begin
    pos_next      = pos;
    len_next      = len;
    len_lo_next   = len_lo;
    magic_lo_next = magic_lo;
    seed_next     = seed;
    stored_next   = stored;
    crc_next      = crc;
    shift_next    = shift;
    size_next     = size;
    idle_next     = idle;
    emit          = 1'b0;
    vcode         = nsbc_pkg::V_OK;
    start_replay  = 1'b0;

    if (state == nsbc_pkg::ST_REPLAY) begin
      crc_next = nsbc_pkg::crc_byte(crc, replay_byte);
    end

    if (pop && head.entry.first_byte) begin
      pos_next    = '0;
      len_next    = '0;
      len_lo_next = '0;
      seed_next   = '0;
      stored_next = '0;
      crc_next    = '0;
      shift_next  = '0;
      size_next   = '0;
      idle_next   = 1'b0;
    end

    if (active) begin
      if (p == PW'(nsbc_pkg::OFF_MAGIC)) begin
        magic_lo_next = b;
      end
      if (p == PW'(nsbc_pkg::OFF_LEN)) begin
        len_lo_next = b;
      end
      if (p == PW'(nsbc_pkg::OFF_LEN + 1)) begin
        len_next = len16[PW-1:0];
      end
      if (p >= PW'(nsbc_pkg::OFF_SEED) && p < PW'(nsbc_pkg::OFF_SEED + 4)) begin
        seed_next[8*p[1:0] +: 8] = b;
      end
      if (p >= PW'(nsbc_pkg::OFF_CRC) && p < PW'(nsbc_pkg::OFF_CRC + 4)) begin
        stored_next[8*p[1:0] +: 8] = b;
      end
      if (p >= PW'(nsbc_pkg::OFF_SHIFT) && p < PW'(nsbc_pkg::OFF_SHIFT + 4)) begin
        shift_next[8*p[1:0] +: 8] = b;
      end
      if (p >= PW'(nsbc_pkg::OFF_SIZE) && p < PW'(nsbc_pkg::OFF_SIZE + 8)) begin
        size_next[8*p[2:0] +: 8] = b;
      end

      // stored crc bytes count as zero
      if (p > PW'(nsbc_pkg::OFF_SEED + 3)) begin
        crc_next = nsbc_pkg::crc_byte(crc,
                     (p < PW'(nsbc_pkg::OFF_CRC + 4)) ? 8'd0 : b);
      end else if (p == PW'(nsbc_pkg::OFF_SEED + 3)) begin
        crc_next = seed_next;
      end

      if (p == PW'(nsbc_pkg::OFF_MAGIC + 1) && {b, magic_lo} != nsbc_pkg::SB_MAGIC) begin
        emit  = 1'b1;
        vcode = nsbc_pkg::V_BAD_MAGIC;
      end else if (p == PW'(nsbc_pkg::OFF_LEN + 1) &&
                   (len16 < nsbc_pkg::MIN_LEN ||
                    len16 > 16'(nsbc_pkg::MAX_CHECKED_BYTES))) begin
        emit  = 1'b1;
        vcode = nsbc_pkg::V_BAD_LENGTH;
      end else if (p == PW'(nsbc_pkg::OFF_SHIFT + 3) &&
                   {b, shift[23:0]} > 32'(nsbc_pkg::MAX_SHIFT)) begin
        emit  = 1'b1;
        vcode = nsbc_pkg::V_BAD_SHIFT;
      end else if (p >= PW'(nsbc_pkg::OFF_SHIFT + 3) && (p + 1'b1) == len) begin
        emit  = 1'b1;
        vcode = (crc_next == stored) ? nsbc_pkg::V_OK : nsbc_pkg::V_CRC_MISMATCH;
      end else if (head.entry.end_of_image) begin
        emit  = 1'b1;
        vcode = nsbc_pkg::V_TRUNCATED;
      end else begin
        pos_next = p + 1'b1;
        start_replay = (p == PW'(nsbc_pkg::OFF_SEED + 3));
      end

      if (emit) begin
        idle_next = 1'b1;
      end
    end
  end

  // size is complete by the time a crc verdict can be given
  assign wrap_sum = {1'b0, image_offset} + {1'b0, size};

  always_ff @(posedge clk) begin
    if (active && p < PW'(nsbc_pkg::HELD_N)) begin
      held[p[nsbc_pkg::HELD_W-1:0]] <= b;
    end
  end

  always_ff @(posedge clk) begin
    len_lo   <= len_lo_next;
    magic_lo <= magic_lo_next;
    seed     <= seed_next;
    stored   <= stored_next;
    crc      <= crc_next;
    shift    <= shift_next;
    size     <= size_next;
    len      <= len_next;
    if (emit) begin
      result.verdict     <= vcode;
      result.block_shift <= (vcode == nsbc_pkg::V_OK) ? shift[2:0] : 3'd0;
      result.device_size <= size_next;
      result.size_usable <= (vcode == nsbc_pkg::V_OK) && (|size[63:10]) &&
                            !wrap_sum[64];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= nsbc_pkg::ST_RUN;
      rcnt         <= '0;
      pos          <= '0;
      idle         <= 1'b1;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      rcnt  <= rcnt_next;
      pos   <= pos_next;
      idle  <= idle_next;
      if (emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_replay_no_pop: assert property (@(posedge clk) disable iff (rst)
    (state == nsbc_pkg::ST_REPLAY) |-> !pop)
    else $error("byte taken during crc replay");

  a_replay_len: assert property (@(posedge clk) disable iff (rst)
    $rose(state == nsbc_pkg::ST_REPLAY) |-> ##16 (state == nsbc_pkg::ST_RUN))
    else $error("crc replay length wrong");

  a_result_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(pop))
    else $error("result without a byte");

  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.verdict != nsbc_pkg::V_OK) |->
      (result.block_shift == 3'd0 && !result.size_usable))
    else $error("failed verdict carries shift or usable flag");
`endif

endmodule

@@ design/nilfs2_superblock_checker_core.sv @@
// ----------------------------------------------------------------------------
// nilfs2_superblock_checker_core
// Checks a streamed superblock: magic, length, block shift and seeded crc-32,
// and gives one verdict word per superblock.
//
//   channel   dir  handshake      payload
//   byte_in   in   valid/ready    data_byte, first_byte, end_of_image
//   result    out  valid/ready    verdict, block_shift, device_size, size_usable
//   cfg       in   cfg_we         cfg_wdata (image offset, 64 bit)
//
// one byte per back-end cycle unless replay or a full result register holds it;
// byte 0x0F starts a byte-wide crc replay of held bytes 0..11 and seed 12..15
// the four-word queue soaks up the first words of a replay or an output stall,
// after that input stalls until the back end pops again
// the back end waits on a full result register; verdicts show the next cycle
// synchronous reset clears control state; no clearing pass is needed
// ----------------------------------------------------------------------------
module nilfs2_superblock_checker_core (
  input  logic         clk,
  input  logic         rst,
  nsbc_in_if.sink      byte_in,
  nsbc_out_if.source   result,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_wdata
);

  logic [63:0]        image_offset;
  nsbc_pkg::q_head_t  head;
  logic               pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_offset <= '0;
    end else if (cfg_we) begin
      image_offset <= cfg_wdata;
    end
  end

  nsbc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .head    (head),
    .pop     (pop)
  );

  nsbc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .image_offset (image_offset),
    .result       (result)
  );

endmodule
